// File: rtl/i2cbb_pkg.sv
// Package for the I2C bit-bang master: item types, config layout and codes.
package i2cbb_pkg;

  // Configuration register widths, indexes and reset values
  localparam int unsigned QuarterW   = 16;
  localparam int unsigned AckLimW    = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgIdxQuarter = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxAckLim  = 1'd1;

  localparam logic [QuarterW-1:0] QuarterRst = 16'd250;
  localparam logic [AckLimW-1:0]  AckLimRst  = 8'd25;

  // Command codes
  localparam logic [2:0] ActStart = 3'd0;
  localparam logic [2:0] ActStop  = 3'd1;
  localparam logic [2:0] ActWrite = 3'd2;
  localparam logic [2:0] ActWait  = 3'd3;
  localparam logic [2:0] ActRead  = 3'd4;

  // Input item: one bus tick
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  // Result item: pin levels and status after the tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_item_t;

  // Configuration seen by the bit engine
  typedef struct packed {
    logic [QuarterW-1:0] quarter_ticks;
    logic [AckLimW-1:0]  ack_limit;
  } cfg_t;

endpackage

// File: rtl/i2cbb_engine.sv
// I2C bit engine: phase sequencer, delay counter and shift register, one tick per step.
module i2cbb_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cbb_pkg::in_item_t in_i,
  input  i2cbb_pkg::cfg_t     cfg_i,
  output i2cbb_pkg::out_item_t res_o
);

  // Phase codes
  localparam logic [4:0] PhIdle  = 5'd0;
  localparam logic [4:0] PhSt1   = 5'd1;
  localparam logic [4:0] PhSt2   = 5'd2;
  localparam logic [4:0] PhSt3   = 5'd3;
  localparam logic [4:0] PhSt4   = 5'd4;
  localparam logic [4:0] PhSp1   = 5'd5;
  localparam logic [4:0] PhSp2   = 5'd6;
  localparam logic [4:0] PhSp3   = 5'd7;
  localparam logic [4:0] PhSp4   = 5'd8;
  localparam logic [4:0] PhWLow  = 5'd9;
  localparam logic [4:0] PhWBit  = 5'd10;
  localparam logic [4:0] PhWHi   = 5'd11;
  localparam logic [4:0] PhWLo   = 5'd12;
  localparam logic [4:0] PhWRel  = 5'd13;
  localparam logic [4:0] PhRLow  = 5'd14;
  localparam logic [4:0] PhRHi   = 5'd15;
  localparam logic [4:0] PhRHold = 5'd16;
  localparam logic [4:0] PhALow  = 5'd17;
  localparam logic [4:0] PhADat  = 5'd18;
  localparam logic [4:0] PhAHi   = 5'd19;
  localparam logic [4:0] PhALo   = 5'd20;
  localparam logic [4:0] PhATail = 5'd21;
  localparam logic [4:0] PhKPoll = 5'd22;
  localparam logic [4:0] PhKTail = 5'd23;

  logic [4:0]                     phase_q, phase_d;
  logic [i2cbb_pkg::QuarterW-1:0] delay_q, delay_d;
  logic [3:0]                     bit_q, bit_d;
  logic [7:0]                     shift_q, shift_d;
  logic [7:0]                     poll_q, poll_d;
  logic                           ack_choice_q, ack_choice_d;
  logic                           scl_q, scl_d;
  logic                           sda_q, sda_d;
  logic [7:0]                     rx_q, rx_d;
  logic                           fail_q, fail_d;

  logic                           done;
  logic                           do_enter;
  logic [4:0]                     target;
  logic [8:0]                     poll_nxt;
  logic [i2cbb_pkg::QuarterW-1:0] delay_dec;
  logic [i2cbb_pkg::QuarterW-1:0] delay_load;
  logic [3:0]                     bit_inc;

  assign poll_nxt   = {1'b0, poll_q} + 9'd1;
  assign delay_dec  = (delay_q != '0) ? delay_q - {{(i2cbb_pkg::QuarterW-1){1'b0}}, 1'b1}
                                      : delay_q;
  assign delay_load = (cfg_i.quarter_ticks != '0) ? cfg_i.quarter_ticks
                                                  : {{(i2cbb_pkg::QuarterW-1){1'b0}}, 1'b1};
  assign bit_inc    = bit_q + 4'd1;

  // Next state for one tick
  always_comb begin
    phase_d      = phase_q;
    delay_d      = delay_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    poll_d       = poll_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    rx_d         = rx_q;
    fail_d       = fail_q;
    done         = 1'b0;
    do_enter     = 1'b0;
    target       = PhIdle;

    if (phase_q == PhIdle) begin
      // command acceptance
      if (in_i.cmd_valid && (in_i.action <= i2cbb_pkg::ActRead)) begin
        bit_d    = 4'd0;
        poll_d   = 8'd0;
        do_enter = 1'b1;
        case (in_i.action)
          i2cbb_pkg::ActStart: target = PhSt1;
          i2cbb_pkg::ActStop:  target = PhSp1;
          i2cbb_pkg::ActWrite: begin
            shift_d = in_i.tx_byte;
            target  = PhWLow;
          end
          i2cbb_pkg::ActWait:  target = PhKPoll;
          default: begin
            ack_choice_d = in_i.send_ack;
            shift_d      = 8'd0;
            sda_d        = 1'b1;
            target       = PhRLow;
          end
        endcase
      end
    end else if (phase_q == PhKPoll) begin
      // acknowledge polling, one sample per tick
      if (!in_i.sda_in) begin
        do_enter = 1'b1;
        target   = PhKTail;
      end else if (poll_nxt > {1'b0, cfg_i.ack_limit}) begin
        scl_d   = 1'b0;
        fail_d  = 1'b1;
        phase_d = PhIdle;
        done    = 1'b1;
      end else begin
        poll_d = poll_nxt[7:0];
      end
    end else begin
      // delay count-down, advance on expiry
      delay_d = delay_dec;
      if (delay_dec == '0) begin
        case (phase_q)
          PhSt1, PhSt2, PhSt3, PhSp1, PhSp2, PhSp3, PhWBit, PhWHi, PhRLow,
          PhALow, PhADat, PhAHi, PhALo: begin
            do_enter = 1'b1;
            target   = phase_q + 5'd1;
          end
          PhWLow: begin
            do_enter = 1'b1;
            target   = PhWBit;
          end
          PhWLo: begin
            bit_d    = bit_inc;
            do_enter = 1'b1;
            target   = (bit_inc < 4'd8) ? PhWBit : PhWRel;
          end
          PhRHi: begin
            shift_d  = {shift_q[6:0], in_i.sda_in};
            do_enter = 1'b1;
            target   = PhRHold;
          end
          PhRHold: begin
            bit_d    = bit_inc;
            do_enter = 1'b1;
            target   = (bit_inc < 4'd8) ? PhRLow : PhALow;
          end
          PhATail: begin
            rx_d    = shift_q;
            phase_d = PhIdle;
            done    = 1'b1;
          end
          PhKTail: begin
            fail_d  = 1'b0;
            phase_d = PhIdle;
            done    = 1'b1;
          end
          default: begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
        endcase
      end
    end

    // phase entry: load delay and set pins
    if (do_enter) begin
      phase_d = target;
      delay_d = delay_load;
      case (target)
        PhSt1:   sda_d = 1'b1;
        PhSt2:   scl_d = 1'b1;
        PhSt3:   sda_d = 1'b0;
        PhSt4:   scl_d = 1'b0;
        PhSp1:   scl_d = 1'b0;
        PhSp2:   sda_d = 1'b0;
        PhSp3:   scl_d = 1'b1;
        PhSp4:   sda_d = 1'b1;
        PhWLow:  scl_d = 1'b0;
        PhWBit: begin
          sda_d   = shift_d[7];
          shift_d = {shift_d[6:0], 1'b0};
        end
        PhWHi:   scl_d = 1'b1;
        PhWLo:   scl_d = 1'b0;
        PhWRel:  sda_d = 1'b1;
        PhRLow:  scl_d = 1'b0;
        PhRHi:   scl_d = 1'b1;
        PhALow:  scl_d = 1'b0;
        PhADat:  sda_d = ~ack_choice_d;
        PhAHi:   scl_d = 1'b1;
        PhALo:   scl_d = 1'b0;
        PhKPoll: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          delay_d = '0;
        end
        PhKTail: scl_d = 1'b0;
        default: ;
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.busy_res   = (phase_d != PhIdle);
    res_o.done_res   = done;
    res_o.rx_byte    = rx_d;
    res_o.ack_failed = fail_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      delay_q      <= '0;
      bit_q        <= 4'd0;
      shift_q      <= 8'd0;
      poll_q       <= 8'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      rx_q         <= 8'd0;
      fail_q       <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      delay_q      <= delay_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      poll_q       <= poll_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      rx_q         <= rx_d;
      fail_q       <= fail_d;
    end
  end

endmodule

// File: rtl/i2c_bitbang_master.sv
// Top level of the I2C bit-bang master: config registers, handshake and result register.
//
// Each input item is one tick of the I2C bit engine and gives exactly one result
// item: the SCL and SDA drive levels, busy, a one-tick done pulse, the last read
// byte and the acknowledge-failure flag after that tick. The engine does the whole
// tick in one pass of logic between its state registers and the result register,
// so one item is taken every clock cycle; a stalled output holds only the items
// behind it, since in_ready_o stays high whenever the result register is empty or
// being emptied. Commands offered while busy, on the finishing tick, or with an
// unknown action are ignored; a quarter_ticks of zero behaves as one.
module i2c_bitbang_master (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  i2cbb_pkg::in_item_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output i2cbb_pkg::out_item_t                 out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [i2cbb_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [i2cbb_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  logic [i2cbb_pkg::QuarterW-1:0] quarter_q;
  logic [i2cbb_pkg::AckLimW-1:0]  ack_lim_q;
  i2cbb_pkg::cfg_t                cfg;
  i2cbb_pkg::out_item_t           res;
  i2cbb_pkg::out_item_t           out_q;
  logic                           out_vld_q;
  logic                           step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_q <= i2cbb_pkg::QuarterRst;
      ack_lim_q <= i2cbb_pkg::AckLimRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cbb_pkg::CfgIdxQuarter: quarter_q <= cfg_wdata_i[i2cbb_pkg::QuarterW-1:0];
        i2cbb_pkg::CfgIdxAckLim:  ack_lim_q <= cfg_wdata_i[i2cbb_pkg::AckLimW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.quarter_ticks = quarter_q;
  assign cfg.ack_limit     = ack_lim_q;

  // Accept when the result register is free or draining
  assign in_ready_o = !out_vld_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  i2cbb_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
